### design/rpfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Holds the command codes, field widths and the frame table entry layout.
// No dependencies.
package rpfa_pkg;

   localparam int CMD_W    = 3;
   localparam int OWNER_W  = 8;
   localparam int PAGE_W   = 10;
   localparam int RUN_W    = 11;
   localparam int PAGES_W  = 11;
   localparam int COUNT_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [PAGES_W-1:0] PAGES_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_LOW  = 3'd0,
      CMD_ALLOC_HIGH = 3'd1,
      CMD_ALLOC_RUN  = 3'd2,
      CMD_FREE       = 3'd3,
      CMD_RESERVE    = 3'd4,
      CMD_RECLAIM    = 3'd5
   } cmd_type;

   // One frame table entry: reference count and owner id
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [OWNER_W-1:0] owner;
   } entry_type;

endpackage

### design/rpfa_frame_ram.sv
// Frame table storage: one write port, one read port, registered read data.
// Depends on rpfa_pkg for the entry layout.
module rpfa_frame_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_W-1:0]     waddr,
   input  rpfa_pkg::entry_type   wdata,
   input  logic [ADDR_W-1:0]     raddr,
   output rpfa_pkg::entry_type   rdata
);

   rpfa_pkg::entry_type frame_mem [DEPTH];
   rpfa_pkg::entry_type rdata_ff;

   // Write the entry and register the read data
   always_ff @(posedge clock) begin
      if (we) begin
         frame_mem[waddr] <= wdata;
      end
      rdata_ff <= frame_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/rpfa_ctrl.sv
// Command sequencer: decodes an item, scans the frame table one entry per
// cycle through the RAM, writes back changes and holds the result register.
// Depends on rpfa_pkg.
module rpfa_ctrl #(
   parameter int NUM_FRAMES = 1024,
   parameter int ADDR_W     = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rpfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rpfa_pkg::OWNER_W-1:0]   req_owner,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_page,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_last_page,
   input  logic [rpfa_pkg::RUN_W-1:0]     req_run_length,
   input  logic [rpfa_pkg::PAGES_W-1:0]   mem_pages,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rpfa_pkg::PAGE_W-1:0]    rsp_frame,
   output logic                           rsp_ok,
   output logic                           mem_we,
   output logic [ADDR_W-1:0]              mem_waddr,
   output rpfa_pkg::entry_type            mem_wdata,
   output logic [ADDR_W-1:0]              mem_raddr,
   input  rpfa_pkg::entry_type            mem_rdata
);

   localparam int CW = (ADDR_W + 1 > rpfa_pkg::RUN_W) ? ADDR_W + 1 : rpfa_pkg::RUN_W;
   localparam logic [CW-1:0]     FRAMES_C = CW'(NUM_FRAMES);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_FRAMES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FILL,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   rpfa_pkg::cmd_type                cmd_ff, cmd_in;
   logic [rpfa_pkg::OWNER_W-1:0]     owner_ff, owner_in;
   logic [rpfa_pkg::RUN_W-1:0]       n_ff, n_in;
   logic [ADDR_W-1:0]                iss_addr_ff, iss_addr_in;
   logic [ADDR_W-1:0]                iss_end_ff, iss_end_in;
   logic                             issue_ff, issue_in;
   logic                             down_ff, down_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]                rd_addr_ff, rd_addr_in;
   logic                             rd_last_ff, rd_last_in;
   logic [CW-1:0]                    run_ff, run_in;
   logic [rpfa_pkg::PAGE_W-1:0]      res_frame_ff, res_frame_in;
   logic                             res_ok_ff, res_ok_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rpfa_pkg::PAGE_W-1:0]      rsp_frame_ff, rsp_frame_in;
   logic                             rsp_ok_ff, rsp_ok_in;

   logic [CW-1:0] page_ext, last_ext, n_ext, pages_ext, top_c, end_c;
   logic [CW-1:0] run_next, first_c;
   logic          cnt_zero, stop;

   assign page_ext  = CW'(req_page);
   assign last_ext  = CW'(req_last_page);
   assign n_ext     = CW'(req_run_length);
   assign pages_ext = CW'(mem_pages);
   assign top_c     = (pages_ext > FRAMES_C) ? FRAMES_C : pages_ext;
   assign end_c     = (last_ext < FRAMES_C) ? last_ext : CW'(LAST_IDX);

   assign cnt_zero  = (mem_rdata.count == '0);
   assign run_next  = cnt_zero ? run_ff + CW'(1) : '0;
   assign first_c   = CW'(rd_addr_ff) + CW'(1) - CW'(n_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      owner_in     = owner_ff;
      n_in         = n_ff;
      iss_addr_in  = iss_addr_ff;
      iss_end_in   = iss_end_ff;
      issue_in     = issue_ff;
      down_in      = down_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = rd_addr_ff;
      rd_last_in   = rd_last_ff;
      run_in       = run_ff;
      res_frame_in = res_frame_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_ok_in    = rsp_ok_ff;
      mem_we       = 1'b0;
      mem_waddr    = rd_addr_ff;
      mem_wdata    = '0;
      mem_raddr    = iss_addr_ff;
      stop         = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // Sweep zeros through the table after reset
            mem_we      = 1'b1;
            mem_waddr   = iss_addr_ff;
            iss_addr_in = iss_addr_ff + ADDR_W'(1);
            if (iss_addr_ff == LAST_IDX) begin
               iss_addr_in = '0;
               state_in    = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = rpfa_pkg::cmd_type'(req_cmd);
               owner_in     = req_owner;
               n_in         = req_run_length;
               run_in       = '0;
               res_frame_in = '0;
               res_ok_in    = 1'b0;
               down_in      = 1'b0;
               issue_in     = 1'b1;
               iss_addr_in  = '0;
               iss_end_in   = LAST_IDX;
               state_in     = S_SCAN;
               case (rpfa_pkg::cmd_type'(req_cmd))
                  rpfa_pkg::CMD_ALLOC_LOW: begin
                  end
                  rpfa_pkg::CMD_ALLOC_HIGH: begin
                     iss_addr_in = ADDR_W'(top_c - CW'(1));
                     iss_end_in  = '0;
                     down_in     = 1'b1;
                     if (top_c == '0) begin
                        issue_in = 1'b0;
                        state_in = S_DONE;
                     end
                  end
                  rpfa_pkg::CMD_ALLOC_RUN: begin
                     iss_addr_in = ADDR_W'(page_ext);
                     if (n_ext == '0 || page_ext >= FRAMES_C) begin
                        issue_in = 1'b0;
                        state_in = S_DONE;
                     end
                  end
                  rpfa_pkg::CMD_FREE: begin
                     iss_addr_in = ADDR_W'(page_ext);
                     iss_end_in  = ADDR_W'(page_ext);
                     if (page_ext >= FRAMES_C) begin
                        issue_in = 1'b0;
                        state_in = S_DONE;
                     end else begin
                        res_ok_in = 1'b1;
                     end
                  end
                  rpfa_pkg::CMD_RESERVE: begin
                     iss_addr_in = ADDR_W'(page_ext);
                     iss_end_in  = ADDR_W'(end_c);
                     res_ok_in   = 1'b1;
                     if (page_ext > end_c) begin
                        issue_in = 1'b0;
                        state_in = S_DONE;
                     end
                  end
                  rpfa_pkg::CMD_RECLAIM: begin
                     res_ok_in = 1'b1;
                  end
                  default: begin
                     issue_in = 1'b0;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue stage: advance the read pointer
            if (issue_ff) begin
               rd_vld_in   = 1'b1;
               rd_addr_in  = iss_addr_ff;
               rd_last_in  = (iss_addr_ff == iss_end_ff);
               issue_in    = (iss_addr_ff != iss_end_ff);
               iss_addr_in = down_ff ? iss_addr_ff - ADDR_W'(1)
                                     : iss_addr_ff + ADDR_W'(1);
            end

            // Data stage: evaluate the entry read last cycle and write back
            if (rd_vld_ff) begin
               case (cmd_ff)
                  rpfa_pkg::CMD_ALLOC_LOW, rpfa_pkg::CMD_ALLOC_HIGH: begin
                     if (cnt_zero) begin
                        mem_we       = 1'b1;
                        mem_wdata    = '{count: rpfa_pkg::COUNT_W'(1), owner: owner_ff};
                        res_frame_in = rpfa_pkg::PAGE_W'(rd_addr_ff);
                        res_ok_in    = 1'b1;
                        stop         = 1'b1;
                     end
                  end
                  rpfa_pkg::CMD_ALLOC_RUN: begin
                     run_in = run_next;
                     if (run_next == CW'(n_ff)) begin
                        res_frame_in = rpfa_pkg::PAGE_W'(first_c);
                        res_ok_in    = 1'b1;
                        stop         = 1'b1;
                     end
                  end
                  rpfa_pkg::CMD_FREE: begin
                     mem_we = 1'b1;
                     if (mem_rdata.count > rpfa_pkg::COUNT_W'(1)) begin
                        mem_wdata.count = mem_rdata.count - rpfa_pkg::COUNT_W'(1);
                        mem_wdata.owner = (mem_rdata.owner == owner_ff) ? '0
                                                                        : mem_rdata.owner;
                     end
                  end
                  rpfa_pkg::CMD_RESERVE: begin
                     if (mem_rdata.count < rpfa_pkg::COUNT_MAX) begin
                        mem_we          = 1'b1;
                        mem_wdata.count = mem_rdata.count + rpfa_pkg::COUNT_W'(1);
                        mem_wdata.owner = mem_rdata.owner;
                     end
                  end
                  rpfa_pkg::CMD_RECLAIM: begin
                     if (!cnt_zero && mem_rdata.owner == owner_ff) begin
                        mem_we = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase

               if (stop && cmd_ff == rpfa_pkg::CMD_ALLOC_RUN) begin
                  // Run found: go back and claim its frames
                  rd_vld_in   = 1'b0;
                  issue_in    = 1'b0;
                  down_in     = 1'b0;
                  iss_addr_in = ADDR_W'(first_c);
                  iss_end_in  = rd_addr_ff;
                  state_in    = S_FILL;
               end else if (stop || rd_last_ff) begin
                  rd_vld_in = 1'b0;
                  issue_in  = 1'b0;
                  state_in  = S_DONE;
               end
            end
         end

         S_FILL: begin
            // Claim one run frame per cycle with owner 0
            mem_we      = 1'b1;
            mem_waddr   = iss_addr_ff;
            mem_wdata   = '{count: rpfa_pkg::COUNT_W'(1), owner: '0};
            iss_addr_in = iss_addr_ff + ADDR_W'(1);
            if (iss_addr_ff == iss_end_ff) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = res_frame_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         iss_addr_ff  <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_addr_ff  <= iss_addr_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      owner_ff     <= owner_in;
      n_ff         <= n_in;
      iss_end_ff   <= iss_end_in;
      down_ff      <= down_in;
      rd_addr_ff   <= rd_addr_in;
      rd_last_ff   <= rd_last_in;
      run_ff       <= run_in;
      res_frame_ff <= res_frame_in;
      res_ok_ff    <= res_ok_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame = rsp_frame_ff;
   assign rsp_ok    = rsp_ok_ff;

   // The table is never written while waiting for an item
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_we)
      else $error("frame table written while idle");

   // Read data is only in flight during a scan
   a_data_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == S_SCAN)
      else $error("read data pending outside a scan");

   // Write-back never collides with the read issued in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && issue_ff && mem_we |-> iss_addr_ff != rd_addr_ff)
      else $error("read and write to the same frame in one cycle");

   // A result is loaded only on leaving the done state
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result loaded outside the done state");

   // A nonzero frame only comes with success
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_ff != '0 |-> rsp_ok_ff)
      else $error("frame reported on a failed command");

endmodule

### design/refcounted_page_frame_allocator_unit.sv
// Reference-counted page frame allocator, top level.
// After reset a clearing pass writes all NUM_FRAMES entries, one per cycle; no item is taken.
// One item at a time: frame entries are visited one per cycle, bound by the single RAM read port.
// Alloc low/high and reclaim scan the table; free visits its one entry.
// Reserve visits its range; alloc run scans, then claims the frames of the run it found.
// Depends on rpfa_pkg, rpfa_frame_ram and rpfa_ctrl.
module refcounted_page_frame_allocator_unit #(
   parameter int NUM_FRAMES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rpfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rpfa_pkg::OWNER_W-1:0]   req_owner,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_page,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_last_page,
   input  logic [rpfa_pkg::RUN_W-1:0]     req_run_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rpfa_pkg::PAGE_W-1:0]    rsp_frame,
   output logic                           rsp_ok,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rpfa_pkg::PAGES_W-1:0]   csr_memory_pages
);

   localparam int AW = $clog2(NUM_FRAMES);

   logic [rpfa_pkg::PAGES_W-1:0] mem_pages_ff, mem_pages_in;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [AW-1:0]                mem_raddr;
   rpfa_pkg::entry_type          mem_wdata;
   rpfa_pkg::entry_type          mem_rdata;

   // Hold the installed page count; an item accepted in the same cycle as a write still uses the old count
   assign csr_ready    = 1'b1;
   assign mem_pages_in = (csr_valid && csr_ready) ? csr_memory_pages : mem_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_pages_ff <= rpfa_pkg::PAGES_RESET;
      end else begin
         mem_pages_ff <= mem_pages_in;
      end
   end

   rpfa_frame_ram #(
      .DEPTH  (NUM_FRAMES),
      .ADDR_W (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rpfa_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .ADDR_W     (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_owner      (req_owner),
      .req_page       (req_page),
      .req_last_page  (req_last_page),
      .req_run_length (req_run_length),
      .mem_pages      (mem_pages_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame      (rsp_frame),
      .rsp_ok         (rsp_ok),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

endmodule

### tb/page_frame_alloc_checker.sv
`timescale 1ns / 1ps
// Checker for the page frame allocator: predicts each result item and compares it.
// Depends on rpfa_pkg; sits beside the block and only watches its channels.
module page_frame_alloc_checker #(
   parameter int FRAMES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [rpfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rpfa_pkg::OWNER_W-1:0]   req_owner,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_page,
   input  logic [rpfa_pkg::PAGE_W-1:0]    req_last_page,
   input  logic [rpfa_pkg::RUN_W-1:0]     req_run_length,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rpfa_pkg::PAGE_W-1:0]    rsp_frame,
   input  logic                           rsp_ok,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rpfa_pkg::PAGES_W-1:0]   csr_memory_pages,
   output int                             mismatch_count,
   output int                             results_owed
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [rpfa_pkg::PAGE_W-1:0] frame;
      logic                        ok;
   } alloc_result_type;

   // Shadow frame table and installed page count
   logic [rpfa_pkg::COUNT_W-1:0] frame_refs [FRAMES];
   logic [rpfa_pkg::OWNER_W-1:0] frame_tags [FRAMES];
   logic [rpfa_pkg::PAGES_W-1:0] installed_pages;
   alloc_result_type             owed_results [$];
   alloc_result_type             seen;
   alloc_result_type             predicted;
   int                           misses = 0;

   // Apply one command to the shadow table and return the result it gives
   function automatic alloc_result_type apply_frame_cmd(
      input logic [rpfa_pkg::CMD_W-1:0]   cmd,
      input logic [rpfa_pkg::OWNER_W-1:0] who,
      input logic [rpfa_pkg::PAGE_W-1:0]  page,
      input logic [rpfa_pkg::PAGE_W-1:0]  last_page,
      input logic [rpfa_pkg::RUN_W-1:0]   want
   );
      alloc_result_type res;
      int i;
      int j;
      int top_frame;
      int free_run;
      int first;
      res = '0;
      case (cmd)
         rpfa_pkg::CMD_ALLOC_LOW: begin
            for (i = 0; i < FRAMES && !res.ok; i++) begin
               if (frame_refs[i] == '0) begin
                  frame_refs[i] = 8'd1;
                  frame_tags[i] = who;
                  res.frame = rpfa_pkg::PAGE_W'(i);
                  res.ok = 1'b1;
               end
            end
         end
         rpfa_pkg::CMD_ALLOC_HIGH: begin
            // clamp the top of memory to the table size
            top_frame = (int'(installed_pages) > FRAMES) ? FRAMES
                                                         : int'(installed_pages);
            for (i = top_frame - 1; i >= 0 && !res.ok; i--) begin
               if (frame_refs[i] == '0) begin
                  frame_refs[i] = 8'd1;
                  frame_tags[i] = who;
                  res.frame = rpfa_pkg::PAGE_W'(i);
                  res.ok = 1'b1;
               end
            end
         end
         rpfa_pkg::CMD_ALLOC_RUN: begin
            // zero length fails without a search
            if (want != '0) begin
               free_run = 0;
               for (i = int'(page); i < FRAMES && !res.ok; i++) begin
                  free_run = (frame_refs[i] == '0) ? free_run + 1 : 0;
                  if (free_run == int'(want)) begin
                     first = i + 1 - free_run;
                     for (j = first; j <= i; j++) begin
                        frame_refs[j] = 8'd1;
                        frame_tags[j] = '0;
                     end
                     res.frame = rpfa_pkg::PAGE_W'(first);
                     res.ok = 1'b1;
                  end
               end
            end
         end
         rpfa_pkg::CMD_FREE: begin
            if (int'(page) < FRAMES) begin
               if (frame_refs[page] > 8'd1) begin
                  if (frame_tags[page] == who) frame_tags[page] = '0;
                  frame_refs[page] = frame_refs[page] - 8'd1;
               end else begin
                  frame_refs[page] = '0;
                  frame_tags[page] = '0;
               end
               res.ok = 1'b1;
            end
         end
         rpfa_pkg::CMD_RESERVE: begin
            // saturate counts, skip frames past the table; an inverted range does nothing
            for (i = int'(page); i <= int'(last_page); i++) begin
               if (i < FRAMES && frame_refs[i] != rpfa_pkg::COUNT_MAX)
                  frame_refs[i] = frame_refs[i] + 8'd1;
            end
            res.ok = 1'b1;
         end
         rpfa_pkg::CMD_RECLAIM: begin
            for (i = 0; i < FRAMES; i++) begin
               if (frame_refs[i] != '0 && frame_tags[i] == who) begin
                  frame_refs[i] = '0;
                  frame_tags[i] = '0;
               end
            end
            res.ok = 1'b1;
         end
         default: begin
            // unused codes leave everything alone and fail
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAMES; k++) begin
            frame_refs[k] = '0;
            frame_tags[k] = '0;
         end
         installed_pages = rpfa_pkg::PAGES_RESET;
         owed_results.delete();
      end else begin
         // score the result item against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            seen.frame = rsp_frame;
            seen.ok = rsp_ok;
            if (owed_results.size() == 0) begin
               misses++;
               if (misses <= REPORT_LIMIT)
                  $display("%0t: unexpected result item frame=%0d ok=%0b",
                           $realtime, seen.frame, seen.ok);
            end else begin
               predicted = owed_results.pop_front();
               if (seen.frame !== predicted.frame || seen.ok !== predicted.ok) begin
                  misses++;
                  if (misses <= REPORT_LIMIT)
                     $display("%0t: result mismatch expected frame=%0d ok=%0b, %s%0d ok=%0b",
                              $realtime, predicted.frame, predicted.ok, "got frame=",
                              seen.frame, seen.ok);
               end
            end
         end
         // track register writes before commands taken at the same edge
         if (csr_valid && csr_ready) installed_pages = csr_memory_pages;
         if (req_valid && req_ready)
            owed_results.push_back(apply_frame_cmd(req_cmd, req_owner, req_page,
                                                   req_last_page, req_run_length));
      end
      mismatch_count <= misses;
      results_owed <= owed_results.size();
   end

endmodule

### tb/refcounted_page_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the page frame allocator: clock, reset, command and register stimulus.
// Depends on rpfa_pkg, the allocator RTL and page_frame_alloc_checker.
module refcounted_page_frame_allocator_unit_tb;

   localparam int FRAMES       = 1024;
   localparam int CYCLE_LIMIT  = 6000000;
   localparam int DRAIN_CYCLES = 2 * FRAMES + 64;
   localparam logic [rpfa_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [rpfa_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_ready;
   logic [rpfa_pkg::CMD_W-1:0]    req_cmd;
   logic [rpfa_pkg::OWNER_W-1:0]  req_owner;
   logic [rpfa_pkg::PAGE_W-1:0]   req_page;
   logic [rpfa_pkg::PAGE_W-1:0]   req_last_page;
   logic [rpfa_pkg::RUN_W-1:0]    req_run_length;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b1;
   logic [rpfa_pkg::PAGE_W-1:0]   rsp_frame;
   logic                          rsp_ok;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [rpfa_pkg::PAGES_W-1:0]  csr_memory_pages;
   int                            mismatch_count;
   int                            results_owed;
   int                            cycle_count = 0;
   int                            rsp_stall_left = 0;
   bit                            idle_on;

   always #6 clock = ~clock;

   refcounted_page_frame_allocator_unit #(
      .NUM_FRAMES(FRAMES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_owner        (req_owner),
      .req_page         (req_page),
      .req_last_page    (req_last_page),
      .req_run_length   (req_run_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame        (rsp_frame),
      .rsp_ok           (rsp_ok),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_memory_pages (csr_memory_pages)
   );

   page_frame_alloc_checker #(
      .FRAMES(FRAMES)
   ) alloc_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_owner        (req_owner),
      .req_page         (req_page),
      .req_last_page    (req_last_page),
      .req_run_length   (req_run_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame        (rsp_frame),
      .rsp_ok           (rsp_ok),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_memory_pages (csr_memory_pages),
      .mismatch_count   (mismatch_count),
      .results_owed     (results_owed)
   );

   // Stall the result side in random bursts while idling is on
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left <= $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[refcounted_page_frame_allocator_unit] ERROR");
         $finish;
      end
   end

   // Present one command item and hold it until taken; maybe idle afterwards
   task automatic send_item(input logic [rpfa_pkg::CMD_W-1:0] cmd,
                            input logic [rpfa_pkg::OWNER_W-1:0] who,
                            input logic [rpfa_pkg::PAGE_W-1:0] page,
                            input logic [rpfa_pkg::PAGE_W-1:0] last_page,
                            input logic [rpfa_pkg::RUN_W-1:0] want);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_owner      <= who;
      req_page       <= page;
      req_last_page  <= last_page;
      req_run_length <= want;
      do @(posedge clock); while (!req_ready);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Drain outstanding commands, then write the installed page count
   task automatic write_pages(input logic [rpfa_pkg::PAGES_W-1:0] pages);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      csr_valid        <= 1'b1;
      csr_memory_pages <= pages;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Random command mix; hot mode piles reserves onto a few frames to reach saturation
   task automatic run_traffic(input int items, input bit hot);
      int                           k;
      int                           pick;
      int                           upper;
      logic [rpfa_pkg::CMD_W-1:0]   cmd;
      logic [rpfa_pkg::OWNER_W-1:0] who;
      logic [rpfa_pkg::PAGE_W-1:0]  page;
      logic [rpfa_pkg::PAGE_W-1:0]  last_page;
      logic [rpfa_pkg::RUN_W-1:0]   want;
      for (k = 0; k < items; k++) begin
         who = ($urandom_range(0, 2) != 0) ? rpfa_pkg::OWNER_W'($urandom_range(0, 7))
                                           : rpfa_pkg::OWNER_W'($urandom_range(0, 255));
         page = rpfa_pkg::PAGE_W'($urandom_range(0, FRAMES - 1));
         last_page = rpfa_pkg::PAGE_W'($urandom_range(0, FRAMES - 1));
         want = rpfa_pkg::RUN_W'($urandom_range(1, 16));
         pick = $urandom_range(0, 99);
         if (hot && $urandom_range(0, 99) < 85) begin
            cmd = rpfa_pkg::CMD_RESERVE;
            page = rpfa_pkg::PAGE_W'($urandom_range(700, 703));
            last_page = rpfa_pkg::PAGE_W'($urandom_range(704, 707));
         end else if (pick < 20) begin
            cmd = rpfa_pkg::CMD_ALLOC_LOW;
         end else if (pick < 34) begin
            cmd = rpfa_pkg::CMD_ALLOC_HIGH;
         end else if (pick < 50) begin
            cmd = rpfa_pkg::CMD_ALLOC_RUN;
            case ($urandom_range(0, 9))
               0: want = '0;
               1: want = rpfa_pkg::RUN_W'($urandom_range(0, 2047));
               2: want = rpfa_pkg::RUN_W'($urandom_range(17, 1024));
               default: ;
            endcase
            if ($urandom_range(0, 1) == 0) page = rpfa_pkg::PAGE_W'($urandom_range(0, 63));
         end else if (pick < 70) begin
            cmd = rpfa_pkg::CMD_FREE;
            case ($urandom_range(0, 3))
               0, 1: page = rpfa_pkg::PAGE_W'($urandom_range(0, 63));
               2: page = rpfa_pkg::PAGE_W'($urandom_range(992, 1023));
               default: ;
            endcase
         end else if (pick < 90) begin
            cmd = rpfa_pkg::CMD_RESERVE;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               upper = int'(page) + $urandom_range(0, 7);
               last_page = rpfa_pkg::PAGE_W'((upper > FRAMES - 1) ? FRAMES - 1 : upper);
            end else if (pick < 8) begin
               // inverted range
               if (page != '0)
                  last_page = rpfa_pkg::PAGE_W'($urandom_range(0, int'(page) - 1));
            end else begin
               last_page = rpfa_pkg::PAGE_W'($urandom_range(int'(page), FRAMES - 1));
            end
         end else if (pick < 95) begin
            cmd = rpfa_pkg::CMD_RECLAIM;
            // keep the hot frames, which belong to owner 0
            if (hot && who == '0) who = 8'd1;
         end else begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
         end
         send_item(cmd, who, page, last_page, want);
      end
   endtask

   initial begin
      req_valid        <= 1'b0;
      req_cmd          <= rpfa_pkg::CMD_ALLOC_LOW;
      req_owner        <= '0;
      req_page         <= '0;
      req_last_page    <= '0;
      req_run_length   <= '0;
      csr_valid        <= 1'b0;
      csr_memory_pages <= '0;
      idle_on          <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_pages(rpfa_pkg::PAGES_RESET);

      // Directed: both ends of the table, free paths, empty range, run failures, full table
      send_item(rpfa_pkg::CMD_ALLOC_LOW,  8'hFF, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_HIGH, 8'h5A, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_LOW,  8'h00, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_FREE,       8'hFF, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_RESERVE,    8'h00, 10'd1,    10'd1,    11'd0);
      send_item(rpfa_pkg::CMD_FREE,       8'h00, 10'd1,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_FREE,       8'h03, 10'd1,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_FREE,       8'h00, 10'd5,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_RESERVE,    8'h00, 10'd10,   10'd9,    11'd0);
      send_item(rpfa_pkg::CMD_RESERVE,    8'h00, 10'd1023, 10'd1023, 11'd0);
      send_item(rpfa_pkg::CMD_FREE,       8'h07, 10'd1023, 10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd1022, 10'd0,    11'd2);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd1023, 10'd0,    11'd1);
      send_item(rpfa_pkg::CMD_RECLAIM,    8'h5A, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd0,    10'd0,    11'd1024);
      send_item(rpfa_pkg::CMD_ALLOC_LOW,  8'h01, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_HIGH, 8'h01, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_RESERVE,    8'h00, 10'd0,    10'd1023, 11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd1000, 10'd0,    11'd1);
      send_item(rpfa_pkg::CMD_FREE,       8'h00, 10'd512,  10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_RECLAIM,    8'h00, 10'd0,    10'd0,    11'd0);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd1000, 10'd0,    11'd24);
      send_item(rpfa_pkg::CMD_ALLOC_RUN,  8'h00, 10'd1023, 10'd1023, 11'd2047);
      send_item(CMD_UNUSED_B,             8'hFF, 10'd1023, 10'd1023, 11'd2047);

      // Random phases across page count settings, idling on
      idle_on <= 1'b1;
      write_pages(11'd1);
      run_traffic(90, 1'b0);
      write_pages(11'd0);
      run_traffic(40, 1'b0);
      write_pages(11'd2047);
      run_traffic(330, 1'b1);
      write_pages(rpfa_pkg::PAGES_W'($urandom_range(2, 1023)));
      run_traffic(80, 1'b0);

      // Last stretch at full rate
      idle_on <= 1'b0;
      write_pages(rpfa_pkg::PAGES_RESET);
      run_traffic(40, 1'b0);

      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[refcounted_page_frame_allocator_unit] OK");
      end else begin
         $display("[refcounted_page_frame_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/rpfa_pkg.sv
design/rpfa_frame_ram.sv
design/rpfa_ctrl.sv
design/refcounted_page_frame_allocator_unit.sv
tb/page_frame_alloc_checker.sv
tb/refcounted_page_frame_allocator_unit_tb.sv
